// ===== rtl/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared constants and types for the RGB to HSV/HSL converter.
// ----------------------------------------------------------------------------
package rhh_pkg;

  // default channel width, in bits
  localparam int CHANNEL_BITS_DEF = 8;

  // hue quotient never exceeds one sixth of a turn (3840), so 12 bits
  localparam int HQ_W = 12;

  // hue scale, 1/64 degree units
  localparam logic [HQ_W-1:0] HUE_SIXTH  = 12'd3840;
  localparam logic [14:0]     HUE_OFF_R  = 15'd0;
  localparam logic [14:0]     HUE_OFF_G  = 15'd7680;
  localparam logic [14:0]     HUE_OFF_B  = 15'd15360;
  localparam logic [14:0]     HUE_TURN   = 15'd23040;

  // output mode
  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  // sideband that rides along the divider chain
  typedef struct packed {
    logic        grey;    // max equals min
    logic        neg;     // hue difference is negative
    logic [14:0] hoff;    // sector offset
    logic [7:0]  bright;  // value or lightness
  } side_t;

endpackage

// ===== rtl/rhh_front.sv =====
// ----------------------------------------------------------------------------
// rhh_front
// Input stage: max/min, sector, divider operands and brightness, registered.
// ----------------------------------------------------------------------------
module rhh_front #(
  parameter int CW = rhh_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  output logic                v_o,
  input  logic                rdy_i,
  output logic [CW+11:0]      hnum_o,
  output logic [CW-1:0]       hden_o,
  output logic [2*CW:0]       snum_o,
  output logic [CW:0]         sden_o,
  output rhh_pkg::side_t      side_o
);
  import rhh_pkg::*;

  localparam logic [CW-1:0] FULL = '1;

  logic [CW+7:0]  rx, gx, bx;
  logic [CW-1:0]  r, g, b, mx, mn, dp, dm, dmag, rng, bv;
  logic [CW:0]    sum, den;
  logic [CW+1:0]  bsum;
  logic [CW+7:0]  bx8;
  logic [CW+11:0] hnum;
  logic [2*CW:0]  snum;
  logic           neg, en;
  side_t          side;

  logic           v_r;
  logic [CW+11:0] hnum_r;
  logic [CW-1:0]  hden_r;
  logic [2*CW:0]  snum_r;
  logic [CW:0]    sden_r;
  side_t          side_r;

  // take the low channel bits
  assign rx = {{CW{1'b0}}, in_red};
  assign gx = {{CW{1'b0}}, in_green};
  assign bx = {{CW{1'b0}}, in_blue};
  assign r  = rx[CW-1:0];
  assign g  = gx[CW-1:0];
  assign b  = bx[CW-1:0];

  // sector select, ties favour red then green
  always_comb begin
    side.hoff = HUE_OFF_R;
    priority if ((r >= g) && (r >= b)) begin
      mx = r; mn = (g < b) ? g : b; dp = g; dm = b;
    end else if (g >= b) begin
      mx = g; mn = (r < b) ? r : b; dp = b; dm = r;
      side.hoff = HUE_OFF_G;
    end else begin
      mx = b; mn = (r < g) ? r : g; dp = r; dm = g;
      side.hoff = HUE_OFF_B;
    end
    neg  = dp < dm;
    dmag = neg ? (dm - dp) : (dp - dm);
    if (neg && (side.hoff == HUE_OFF_R)) begin
      side.hoff = HUE_TURN;
    end
  end

  assign rng  = mx - mn;
  assign sum  = {1'b0, mx} + {1'b0, mn};
  assign hnum = (CW+12)'(dmag) * (CW+12)'(HUE_SIXTH);

  // saturation divisor per mode
  always_comb begin
    if (mode == MODE_HSV) begin
      den = {1'b0, mx};
    end else if (sum <= {1'b0, FULL}) begin
      den = sum;
    end else begin
      den = {FULL, 1'b0} - sum;
    end
  end

  // range*FULL plus half divisor for rounding
  assign snum = (2*CW+1)'({rng, {CW{1'b0}}}) - (2*CW+1)'(rng) + (2*CW+1)'(den >> 1);

  // brightness
  assign bsum = {1'b0, sum} + (CW+2)'(1);
  assign bv   = (mode == MODE_HSV) ? mx : bsum[CW:1];
  assign bx8  = {8'b0, bv};

  assign side.grey   = (rng == '0);
  assign side.neg    = neg;
  assign side.bright = bx8[7:0];

  // elastic stage
  assign en       = !v_r || rdy_i;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      hnum_r <= hnum;
      hden_r <= rng;
      snum_r <= snum;
      sden_r <= den;
      side_r <= side;
    end
  end

  assign v_o    = v_r;
  assign hnum_o = hnum_r;
  assign hden_o = hden_r;
  assign snum_o = snum_r;
  assign sden_o = sden_r;
  assign side_o = side_r;

endmodule

// ===== rtl/rhh_cell.sv =====
// ----------------------------------------------------------------------------
// rhh_cell
// One restoring division step for both the hue and the saturation quotient.
// ----------------------------------------------------------------------------
module rhh_cell #(
  parameter int CW = rhh_pkg::CHANNEL_BITS_DEF,
  parameter int L  = 12,
  parameter int K  = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            v_i,
  output logic            rdy_o,
  input  logic [CW+11:0]  hnum_i,
  input  logic [CW-1:0]   hden_i,
  input  logic [L-1:0]    hq_i,
  input  logic [2*CW:0]   snum_i,
  input  logic [CW:0]     sden_i,
  input  logic [L-1:0]    sq_i,
  input  rhh_pkg::side_t  side_i,
  output logic            v_o,
  input  logic            rdy_i,
  output logic [CW+11:0]  hnum_o,
  output logic [CW-1:0]   hden_o,
  output logic [L-1:0]    hq_o,
  output logic [2*CW:0]   snum_o,
  output logic [CW:0]     sden_o,
  output logic [L-1:0]    sq_o,
  output rhh_pkg::side_t  side_o
);
  import rhh_pkg::*;

  localparam int HW = ((CW + 12) > (CW + L)) ? (CW + 12) : (CW + L);
  localparam int SW = ((2*CW + 1) > (CW + 1 + L)) ? (2*CW + 1) : (CW + 1 + L);

  logic [HW-1:0] hsh, hdif;
  logic [SW-1:0] ssh, sdif;
  logic          hge, sge, en;
  logic [L-1:0]  hq, sq;

  logic            v_r;
  logic [CW+11:0]  hnum_r;
  logic [CW-1:0]   hden_r;
  logic [L-1:0]    hq_r;
  logic [2*CW:0]   snum_r;
  logic [CW:0]     sden_r;
  logic [L-1:0]    sq_r;
  side_t           side_r;

  // trial subtract of divisor shifted to this bit
  always_comb begin
    hsh  = HW'(hden_i) << K;
    hge  = HW'(hnum_i) >= hsh;
    hdif = HW'(hnum_i) - hsh;
    ssh  = SW'(sden_i) << K;
    sge  = SW'(snum_i) >= ssh;
    sdif = SW'(snum_i) - ssh;
    hq   = hq_i;
    sq   = sq_i;
    hq[K] = hge;
    sq[K] = sge;
  end

  assign en    = !v_r || rdy_i;
  assign rdy_o = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_i) begin
      hnum_r <= hge ? (CW+12)'(hdif) : hnum_i;
      snum_r <= sge ? (2*CW+1)'(sdif) : snum_i;
      hden_r <= hden_i;
      sden_r <= sden_i;
      hq_r   <= hq;
      sq_r   <= sq;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign hnum_o = hnum_r;
  assign hden_o = hden_r;
  assign hq_o   = hq_r;
  assign snum_o = snum_r;
  assign sden_o = sden_r;
  assign sq_o   = sq_r;
  assign side_o = side_r;

endmodule

// ===== rtl/rhh_back.sv =====
// ----------------------------------------------------------------------------
// rhh_back
// Output register: sector fix-up of the hue, grey override, result word.
// ----------------------------------------------------------------------------
module rhh_back #(
  parameter int L = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            v_i,
  output logic            rdy_o,
  input  logic [L-1:0]    hq_i,
  input  logic [L-1:0]    sq_i,
  input  rhh_pkg::side_t  side_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [14:0]     out_hue,
  output logic [7:0]      out_saturation,
  output logic [7:0]      out_brightness
);
  import rhh_pkg::*;

  logic [14:0] q15, hsum, hue;
  logic [7:0]  sat;
  logic        en;

  logic        v_r;
  logic [14:0] hue_r;
  logic [7:0]  sat_r, bright_r;

  // apply sector offset, wrap a full turn to zero
  always_comb begin
    q15  = 15'(hq_i[HQ_W-1:0]);
    hsum = side_i.neg ? (side_i.hoff - q15) : (side_i.hoff + q15);
    hue  = (hsum >= HUE_TURN) ? (hsum - HUE_TURN) : hsum;
    sat  = sq_i[7:0];
    if (side_i.grey) begin
      hue = '0;
      sat = '0;
    end
  end

  assign en    = !v_r || out_ready;
  assign rdy_o = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_i) begin
      hue_r    <= hue;
      sat_r    <= sat;
      bright_r <= side_i.bright;
    end
  end

  assign out_valid      = v_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

// ===== rtl/rgb_to_hsv_hsl_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_unit
// Per-pixel RGB to HSV/HSL conversion over a chain of divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one pixel word (red, green, blue).
//   Output channel out_valid/out_ready carries one word (hue in 1/64 degree,
//   saturation, brightness) per pixel, in order.
//   cfg_we writes the mode bit (0 HSV, 1 HSL); write only while idle.
// Data path, L = max(12, CHANNEL_BITS): the front stage loads at the
//   accepting edge, then each word passes through L division cells (one
//   quotient bit each for the hue and the saturation divider) and the
//   output register.
// Throughput: one pixel per clock, sustained while out_ready stays high.
// Every stage is elastic: a stalled receiver holds the output word and the
//   empty stages behind it keep filling, so in_ready drops only once the
//   whole chain is full.
// Reset (rst_n low, synchronous) empties all stages and sets mode to HSV.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_unit #(
  parameter int CHANNEL_BITS = rhh_pkg::CHANNEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_hue,
  output logic [7:0]  out_saturation,
  output logic [7:0]  out_brightness
);
  import rhh_pkg::*;

  localparam int CW = CHANNEL_BITS;
  localparam int L  = (CW > HQ_W) ? CW : HQ_W;

  logic mode_r;

  logic           v_w    [0:L];
  logic           rdy_w  [0:L];
  logic [CW+11:0] hnum_w [0:L];
  logic [CW-1:0]  hden_w [0:L];
  logic [L-1:0]   hq_w   [0:L];
  logic [2*CW:0]  snum_w [0:L];
  logic [CW:0]    sden_w [0:L];
  logic [L-1:0]   sq_w   [0:L];
  side_t          side_w [0:L];

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HSV;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  rhh_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .v_o      (v_w[0]),
    .rdy_i    (rdy_w[0]),
    .hnum_o   (hnum_w[0]),
    .hden_o   (hden_w[0]),
    .snum_o   (snum_w[0]),
    .sden_o   (sden_w[0]),
    .side_o   (side_w[0])
  );

  assign hq_w[0] = '0;
  assign sq_w[0] = '0;

  // quotient bits, most significant first
  for (genvar i = 1; i <= L; i++) begin : g_cell
    rhh_cell #(.CW(CW), .L(L), .K(L - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .v_i    (v_w[i-1]),
      .rdy_o  (rdy_w[i-1]),
      .hnum_i (hnum_w[i-1]),
      .hden_i (hden_w[i-1]),
      .hq_i   (hq_w[i-1]),
      .snum_i (snum_w[i-1]),
      .sden_i (sden_w[i-1]),
      .sq_i   (sq_w[i-1]),
      .side_i (side_w[i-1]),
      .v_o    (v_w[i]),
      .rdy_i  (rdy_w[i]),
      .hnum_o (hnum_w[i]),
      .hden_o (hden_w[i]),
      .hq_o   (hq_w[i]),
      .snum_o (snum_w[i]),
      .sden_o (sden_w[i]),
      .sq_o   (sq_w[i]),
      .side_o (side_w[i])
    );
  end

  rhh_back #(.L(L)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .v_i            (v_w[L]),
    .rdy_o          (rdy_w[L]),
    .hq_i           (hq_w[L]),
    .sq_i           (sq_w[L]),
    .side_i         (side_w[L]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

endmodule

// ===== rtl/rhh_checker.sv =====
// ----------------------------------------------------------------------------
// rhh_checker
// Port-level assertions for rgb_to_hsv_hsl_unit, attached by bind.
// ----------------------------------------------------------------------------
module rhh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_hue,
  input logic [7:0]  out_saturation,
  input logic [7:0]  out_brightness
);
  import rhh_pkg::*;

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hue)
      && $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled output word changed");

  // hue stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_TURN)
    else $error("hue out of range");

  // input side is never blocked while the output is idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && $past(!out_valid) && $past(!in_valid) |-> in_ready)
    else $error("in_ready low with empty output");

endmodule

bind rgb_to_hsv_hsl_unit rhh_checker u_rhh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hue        (out_hue),
  .out_saturation (out_saturation),
  .out_brightness (out_brightness)
);

// ===== sim/tb_rgb_to_hsv_hsl_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_hsl_unit
// Streams pixels through the RGB to HSV/HSL converter in both modes, with a
// directed table of corner colors followed by random pixels. Every output
// word is compared field by field with an in-order queue of predicted words.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_hsl_unit;
  import rhh_pkg::*;

  localparam int LATENCY = 14;
  localparam int N_RANDOM = 1600;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  bright;
  } hsx_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       known;  // expected word typed in below
    hsx_t       res;
  } pix_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] out_hue;
  logic [7:0]  out_saturation;
  logic [7:0]  out_brightness;

  logic        mode_q;
  hsx_t        expected_q[$];
  int          n_errors;
  int          n_words;
  int          n_pixels;
  bit          stall_en;

  rgb_to_hsv_hsl_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Rounded quotient, halves up
  function automatic logic [31:0] div_near(logic [31:0] num, logic [31:0] den);
    if (den == 0) return 0;
    return (num + den / 2) / den;
  endfunction

  // Predicted hue / saturation / brightness for one pixel
  function automatic hsx_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic md);
    int   mx;
    int   mn;
    int   rng;
    int   sum;
    int   h;
    hsx_t o;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    rng = mx - mn;
    sum = mx + mn;
    o = '0;
    if (rng != 0) begin
      // SV integer division truncates toward zero
      if (mx == r) h = (3840 * (int'(g) - int'(b))) / rng + ((g < b) ? 23040 : 0);
      else if (mx == g) h = (3840 * (int'(b) - int'(r))) / rng + 7680;
      else h = (3840 * (int'(r) - int'(g))) / rng + 15360;
      if (h >= 23040) h -= 23040;
      if (h < 0) h = 0;
      o.hue = h[14:0];
      if (md == MODE_HSV) o.sat = 8'(div_near(rng * 255, mx));
      else if (sum <= 255) o.sat = 8'(div_near(rng * 255, sum));
      else o.sat = 8'(div_near(rng * 255, 510 - sum));
    end
    o.bright = (md == MODE_HSV) ? mx[7:0] : 8'((sum + 1) >> 1);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch word %0d: %s got %0d expected %0d", n_words, what, got, want);
    n_errors++;
  endtask

  // Output side: random stalls once stall_en is set, compare each word
  always @(posedge clk) begin
    hsx_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, queue", 0, 1);
      end else begin
        e = expected_q.pop_front();
        if (out_hue !== e.hue) report_mismatch("hue", out_hue, e.hue);
        if (out_saturation !== e.sat) report_mismatch("saturation", out_saturation, e.sat);
        if (out_brightness !== e.bright)
          report_mismatch("brightness", out_brightness, e.bright);
      end
      n_words++;
    end
    if (!stall_en) out_ready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_ready <= 1'b0;
    else if (!out_ready && $urandom_range(0, 99) < 40) out_ready <= 1'b1;
    else if ($urandom_range(0, 99) < 15) out_ready <= ~out_ready;
  end

  task automatic idle_gap();
    int n;
    if (!stall_en) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                     : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one pixel; expectation queued at acceptance, valid left to the caller
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(convert_pixel(r, g, b, mode_q));
    n_pixels++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_mode(logic md);
    cfg_we    <= 1'b1;
    cfg_wdata <= md;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_q = md;
  endtask

  task automatic random_pixels(int n);
    logic [7:0] r, g, b;
    for (int i = 0; i < n; i++) begin
      idle_gap();
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(0, 7))
        0: g = r;               // ties
        1: begin g = r; b = r; end  // grey
        2: b = g;
        3: begin r = 8'hff; b = 8'h00; end
        default: ;
      endcase
      send_pixel(r, g, b);
      // pause until the pipe is empty
      if (i % 400 == 200) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  pix_row_t dir_tbl[] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     8'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     8'd0,   8'd128}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     8'd255, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  8'd255, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 8'd255, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{8'd254, 8'd255, 8'd1,   1'b0, '0},
    '{8'd12,  8'd200, 8'd99,  1'b0, '0},
    '{8'd55,  8'd170, 8'd254, 1'b0, '0},
    '{8'd128, 8'd127, 8'd127, 1'b0, '0}
  };

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    out_ready = 1'b1;
    stall_en  = 1'b0;
    mode_q    = MODE_HSV;
    n_errors  = 0;
    n_words   = 0;
    n_pixels  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table in reset mode (HSV), then HSL
    for (int m = 0; m < 2; m++) begin
      if (m == 1) set_mode(MODE_HSL);
      foreach (dir_tbl[k]) begin
        send_pixel(dir_tbl[k].r, dir_tbl[k].g, dir_tbl[k].b);
        if (m == 0 && dir_tbl[k].known) expected_q[$] = dir_tbl[k].res;
      end
      drain();
    end

    // Random phases: HSL, HSV, HSL, no stalls at first then with stalls
    random_pixels(150);
    drain();
    stall_en = 1'b1;
    set_mode(MODE_HSV);
    random_pixels(N_RANDOM / 2);
    drain();
    set_mode(MODE_HSL);
    random_pixels(N_RANDOM / 2);
    drain();

    $display("covered %0d pixels and %0d output words in HSV and HSL modes,",
             n_pixels, n_words);
    $display("with corner colors, ties, grey pixels and random stalls on both sides");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (expected_q.size() != 0)
        $display("%0d expected words never arrived", expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
